FILE: sv/mexp_pkg.sv
// Shared constants, types and command/status structs of the modular exponentiation block.
package mexp_pkg;

  localparam int OPERAND_BITS = 32;
  localparam int FIELD_BITS   = 32;
  localparam int CNT_BITS     = $clog2(OPERAND_BITS);

  typedef logic [OPERAND_BITS-1:0] opnd_t;
  typedef logic [FIELD_BITS-1:0]   field_t;
  typedef logic [CNT_BITS-1:0]     cnt_t;

  typedef enum logic [1:0] {
    MSEL_REDUCE = 2'd0,
    MSEL_ACC    = 2'd1,
    MSEL_SQR    = 2'd2
  } mul_sel_t;

  typedef enum logic {
    DST_BASE = 1'b0,
    DST_ACC  = 1'b1
  } mul_dst_t;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     mul_step;
    mul_dst_t mul_dst;
    logic     acc_init;
    logic     acc_clear;
    logic     exp_shift;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic base_zero;
    logic exp_zero;
    logic exp_upper_zero;
    logic exp_lsb;
    logic mul_last;
  } dp_status_t;

endpackage

FILE: sv/mexp_if.sv
// Valid/ready channel interfaces for the input words and the result words.
interface mexp_in_if;
  logic                    valid;
  logic                    ready;
  mexp_pkg::field_t        base_value;
  mexp_pkg::field_t        exponent;

  modport source (output valid, output base_value, output exponent, input ready);
  modport sink (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_out_if;
  logic                    valid;
  logic                    ready;
  mexp_pkg::field_t        power_mod;

  modport source (output valid, output power_mod, input ready);
  modport sink (input valid, input power_mod, output ready);
endinterface

FILE: sv/mexp_datapath.sv
// Datapath: modulus register, operand registers and the bit-serial modular multiplier.
module mexp_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mexp_pkg::dp_cmd_t     cmd,
  output mexp_pkg::dp_status_t  status,
  input  mexp_pkg::field_t      in_base_value,
  input  mexp_pkg::field_t      in_exponent,
  input  logic                  cfg_wr_en,
  input  mexp_pkg::field_t      cfg_wr_data,
  output mexp_pkg::field_t      out_power_mod,
  output mexp_pkg::opnd_t       modulus_eff
);
  import mexp_pkg::*;

  field_t modulus_r;
  opnd_t  n;
  opnd_t  base_r;
  opnd_t  exp_r;
  opnd_t  acc_r;
  opnd_t  mx_r;
  opnd_t  my_r;
  opnd_t  prod_r;
  cnt_t   cnt_r;
  field_t out_data_r;

  logic [OPERAND_BITS:0] dbl_w;
  logic [OPERAND_BITS:0] sum_w;
  logic [OPERAND_BITS:0] n_ext;
  opnd_t                 dbl_red;
  opnd_t                 add_red;
  opnd_t                 step_val;

  assign n     = OPERAND_BITS'(modulus_r);
  assign n_ext = {1'b0, n};

  // One multiplier bit per cycle: double modulo n, then add x modulo n when the bit is set.
  // Both sums stay below twice the modulus, so one conditional subtract suffices.
  always_comb begin
    dbl_w    = {prod_r, 1'b0};
    dbl_red  = (dbl_w >= n_ext) ? OPERAND_BITS'(dbl_w - n_ext) : OPERAND_BITS'(dbl_w);
    sum_w    = {1'b0, dbl_red} + {1'b0, mx_r};
    add_red  = (sum_w >= n_ext) ? OPERAND_BITS'(sum_w - n_ext) : OPERAND_BITS'(sum_w);
    step_val = my_r[OPERAND_BITS-1] ? add_red : dbl_red;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= FIELD_BITS'(1);
    end else if (cfg_wr_en) begin
      modulus_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= OPERAND_BITS'(in_base_value);
      exp_r  <= OPERAND_BITS'(in_exponent);
    end
    if (cmd.mul_start) begin
      case (cmd.mul_sel)
        MSEL_REDUCE: mx_r <= OPERAND_BITS'(1);
        MSEL_ACC:    mx_r <= acc_r;
        default:     mx_r <= base_r;
      endcase
      my_r   <= base_r;
      prod_r <= '0;
      cnt_r  <= CNT_BITS'(OPERAND_BITS - 1);
    end
    if (cmd.mul_step) begin
      prod_r <= step_val;
      my_r   <= my_r << 1;
      cnt_r  <= cnt_r - CNT_BITS'(1);
      if (cnt_r == '0) begin
        if (cmd.mul_dst == DST_ACC) begin
          acc_r <= step_val;
        end else begin
          base_r <= step_val;
        end
      end
    end
    if (cmd.acc_init) begin
      acc_r <= (n == OPERAND_BITS'(1)) ? '0 : OPERAND_BITS'(1);
    end
    if (cmd.acc_clear) begin
      acc_r <= '0;
    end
    if (cmd.exp_shift) begin
      exp_r <= exp_r >> 1;
    end
    if (cmd.out_load) begin
      out_data_r <= FIELD_BITS'(acc_r);
    end
  end

  assign status.n_zero         = (n == '0);
  assign status.base_zero      = (base_r == '0);
  assign status.exp_zero       = (exp_r == '0);
  assign status.exp_upper_zero = ((exp_r >> 1) == '0);
  assign status.exp_lsb        = exp_r[0];
  assign status.mul_last       = (cnt_r == '0);

  assign out_power_mod = out_data_r;
  assign modulus_eff   = n;

endmodule

FILE: sv/mexp_ctrl.sv
// Controller: sequences reduction, square-and-multiply steps and the result register.
module mexp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  mexp_pkg::dp_status_t  status,
  output mexp_pkg::dp_cmd_t     cmd
);
  import mexp_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PREP  = 9'b000000010,
    S_RED   = 9'b000000100,
    S_BCHK  = 9'b000001000,
    S_LOOP  = 9'b000010000,
    S_MACC  = 9'b000100000,
    S_SHIFT = 9'b001000000,
    S_MSQR  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (status.n_zero) begin
          cmd.acc_clear = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_REDUCE;
          state_nxt     = S_RED;
        end
      end
      S_RED: begin
        cmd.mul_step = 1'b1;
        cmd.mul_dst  = DST_BASE;
        if (status.mul_last) begin
          state_nxt = S_BCHK;
        end
      end
      S_BCHK: begin
        // A base that reduces to zero gives zero even for a zero exponent.
        if (status.base_zero) begin
          cmd.acc_clear = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.acc_init = 1'b1;
          state_nxt    = S_LOOP;
        end
      end
      S_LOOP: begin
        if (status.exp_zero) begin
          state_nxt = S_DONE;
        end else if (status.exp_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_ACC;
          state_nxt     = S_MACC;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_MACC: begin
        cmd.mul_step = 1'b1;
        cmd.mul_dst  = DST_ACC;
        if (status.mul_last) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.exp_shift = 1'b1;
        // The squaring after the last exponent bit would not be used, so it is skipped.
        if (status.exp_upper_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MSEL_SQR;
          state_nxt     = S_MSQR;
        end
      end
      S_MSQR: begin
        cmd.mul_step = 1'b1;
        cmd.mul_dst  = DST_BASE;
        if (status.mul_last) begin
          state_nxt = S_LOOP;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: sv/modular_exponentiation.sv
// Top level of the modular exponentiation block: base^exponent mod modulus.
//
// Usage: a word on the input channel carries base_value and exponent; the
// block returns one word on the result channel with power_mod, the base raised
// to the exponent modulo the modulus register, by right-to-left binary
// square-and-multiply. The modulus resets to one and must be written by the
// user via cfg_wr_en/cfg_wr_data while the block is idle; this is not enforced.
//
// Multiplier: each modular product is formed by a shift-and-add multiplier that
// handles one multiplier bit per cycle. Each accepted word goes through the
// base reduction and the checks, then a multiply into the accumulator for each
// set exponent bit and a squaring of the base for each exponent bit below the
// top one. The multiplier is shared, so one item is in work at a time.
//
// The result sits in an output register; the next word is accepted while it
// waits. If the receiver stalls, the finished next result waits in the
// controller until the register frees. Reset empties the channel and sets the
// modulus to one.
module modular_exponentiation (
  input  logic              clk,
  input  logic              rst_n,
  mexp_in_if.sink           in_ch,
  mexp_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  mexp_pkg::field_t  cfg_wr_data
);
  import mexp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  opnd_t      modulus_eff;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mexp_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_base_value (in_ch.base_value),
    .in_exponent   (in_ch.exponent),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_power_mod (out_ch.power_mod),
    .modulus_eff   (modulus_eff)
  );

  // A shown result is always reduced below a nonzero modulus.
  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (modulus_eff != '0) |-> (OPERAND_BITS'(out_ch.power_mod) < modulus_eff))
    else $error("result not below modulus");

  // Once a word is taken the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while busy");

  // A new result only appears after the block was busy finishing it.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result appeared from idle");

endmodule
